// ----- hdl/rrt_pkg.sv -----
`default_nettype none

package rrt_pkg;

   // Fixed field widths of the channels and the register file.
   localparam int OUT_FIELDS    = 4;
   localparam int OUT_BITS      = 16;
   localparam int CFG_BITS      = 16;
   localparam int LEVEL_BITS    = 4;
   localparam int MODE_BITS     = 2;
   localparam int FIELD_BITS    = $clog2(OUT_FIELDS);
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   // Linear map onto 1..MAP_TOP and the divider that serves it.
   localparam int MAP_TOP   = 1000;
   localparam int Q_BITS    = 10;
   localparam int PROD_BITS = CFG_BITS + Q_BITS;
   localparam int STEP_BITS = $clog2(Q_BITS);
   localparam logic [Q_BITS-1:0] MAP_SCALE = Q_BITS'(MAP_TOP - 1);

   // Input transaction modes.
   localparam logic [MODE_BITS-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_START = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd2;

   // Register indexes, selected by the word address bit.
   localparam logic REG_MIN_TIME = 1'b0;
   localparam logic REG_MAX_TIME = 1'b1;

   // Register reset values.
   localparam logic [CFG_BITS-1:0] MIN_TIME_RESET = 16'd1;
   localparam logic [CFG_BITS-1:0] MAX_TIME_RESET = 16'd8000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                  tick;
      logic                  start;
      logic                  read;
      logic                  pick;
      logic                  mul;
      logic                  div_step;
      logic                  store;
      logic                  load_out;
      logic [FIELD_BITS-1:0] field;
   } rrt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic use_div;
   } rrt_status_type;

endpackage

`default_nettype wire

// ----- hdl/rrt_req_if.sv -----
`default_nettype none

interface rrt_req_if;
   logic                           valid;
   logic                           ready;
   logic [rrt_pkg::MODE_BITS-1:0]  mode;
   logic [rrt_pkg::LEVEL_BITS-1:0] line_levels;
   logic                           raw;

   modport source (output valid, output mode, output line_levels, output raw, input ready);
   modport sink (input valid, input mode, input line_levels, input raw, output ready);
endinterface

`default_nettype wire

// ----- hdl/rrt_rsp_if.sv -----
`default_nettype none

interface rrt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rrt_pkg::OUT_BITS-1:0] front_left_value;
   logic [rrt_pkg::OUT_BITS-1:0] front_right_value;
   logic [rrt_pkg::OUT_BITS-1:0] rear_left_value;
   logic [rrt_pkg::OUT_BITS-1:0] rear_right_value;

   modport source (output valid, output front_left_value, output front_right_value,
                   output rear_left_value, output rear_right_value, input ready);
   modport sink (input valid, input front_left_value, input front_right_value,
                 input rear_left_value, input rear_right_value, output ready);
endinterface

`default_nettype wire

// ----- hdl/rrt_dp.sv -----
`default_nettype none

module rrt_dp #(
   parameter int TIME_BITS = 16,
   parameter int CHANNELS  = 4
) (
   input  wire logic                                               clock,
   input  wire logic                                               reset,
   input  wire rrt_pkg::rrt_cmd_type                               cmd,
   output rrt_pkg::rrt_status_type                                 status,
   input  wire logic [rrt_pkg::LEVEL_BITS-1:0]                     line_levels,
   input  wire logic                                               raw,
   input  wire logic [rrt_pkg::CFG_BITS-1:0]                       min_time,
   input  wire logic [rrt_pkg::CFG_BITS-1:0]                       max_time,
   output logic [rrt_pkg::OUT_FIELDS-1:0][rrt_pkg::OUT_BITS-1:0]   out_value
);

   localparam int CMP_BITS = (TIME_BITS > rrt_pkg::CFG_BITS) ? TIME_BITS : rrt_pkg::CFG_BITS;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   logic [TIME_BITS-1:0]                                 count_ff, count_in, count_sat;
   logic [CHANNELS-1:0]                                  prev_ff, prev_in, level_now;
   logic [CHANNELS-1:0][TIME_BITS-1:0]                   edge_ff, edge_in;
   logic                                                 raw_ff, raw_in;
   logic [rrt_pkg::CFG_BITS-1:0]                         diff_ff, diff_in;
   logic [rrt_pkg::CFG_BITS-1:0]                         range_ff, range_in;
   logic [rrt_pkg::PROD_BITS-1:0]                        rem_ff, rem_in;
   logic [rrt_pkg::PROD_BITS-1:0]                        dsr_ff, dsr_in;
   logic [rrt_pkg::Q_BITS-1:0]                           quo_ff, quo_in;
   logic [rrt_pkg::OUT_FIELDS-1:0][rrt_pkg::OUT_BITS-1:0] res_ff, res_in;
   logic [rrt_pkg::OUT_FIELDS-1:0][rrt_pkg::OUT_BITS-1:0] out_ff, out_in;
   logic [rrt_pkg::OUT_FIELDS-1:0][TIME_BITS-1:0]        field_time;

   logic [TIME_BITS-1:0]         t_sel;
   logic [CMP_BITS-1:0]          t_ext, lo_ext, hi_ext;
   logic [rrt_pkg::CFG_BITS-1:0] t_clamp;
   logic [rrt_pkg::OUT_BITS-1:0] direct_value;
   logic                         t_zero, degenerate, use_div, div_ge;

   // Channels beyond the physical lines see a low level.
   for (genvar j = 0; j < CHANNELS; j++) begin : g_level
      if (j < rrt_pkg::LEVEL_BITS) begin : g_line
         assign level_now[j] = line_levels[j];
      end else begin : g_none
         assign level_now[j] = 1'b0;
      end
   end

   // Output fields without a channel read as no edge.
   for (genvar j = 0; j < rrt_pkg::OUT_FIELDS; j++) begin : g_field
      if (j < CHANNELS) begin : g_chan
         assign field_time[j] = edge_ff[j];
      end else begin : g_empty
         assign field_time[j] = '0;
      end
   end

   assign count_sat = (count_ff == TIME_MAX) ? count_ff : count_ff + TIME_BITS'(1);

   // Elapsed counter, edge detection and capture.
   always_comb begin
      count_in = count_ff;
      prev_in  = prev_ff;
      edge_in  = edge_ff;
      if (cmd.start) begin
         count_in = '0;
         edge_in  = '0;
      end else if (cmd.tick) begin
         count_in = count_sat;
         for (int j = 0; j < CHANNELS; j++) begin
            if (prev_ff[j] && !level_now[j]) begin
               edge_in[j] = count_sat;
            end
         end
         prev_in = level_now;
      end else if (cmd.load_out) begin
         edge_in = '0;
      end
   end

   // Selection of the current field and the clamp into the calibrated range.
   always_comb begin
      t_sel      = field_time[cmd.field];
      t_ext      = CMP_BITS'(t_sel);
      lo_ext     = CMP_BITS'(min_time);
      hi_ext     = CMP_BITS'(max_time);
      t_zero     = (t_sel == '0);
      degenerate = (max_time <= min_time);
      if (t_ext < lo_ext) begin
         t_clamp = min_time;
      end else if (t_ext > hi_ext) begin
         t_clamp = max_time;
      end else begin
         t_clamp = t_ext[rrt_pkg::CFG_BITS-1:0];
      end
      if (t_zero) begin
         direct_value = '0;
      end else if (raw_ff) begin
         direct_value = t_ext[rrt_pkg::OUT_BITS-1:0];
      end else begin
         direct_value = rrt_pkg::OUT_BITS'(1);
      end
      use_div = !t_zero && !raw_ff && !degenerate;
   end

   assign status.use_div = use_div;
   assign div_ge         = (rem_ff >= dsr_ff);

   // Scaling multiply, restoring divider and result assembly.
   always_comb begin
      raw_in   = raw_ff;
      diff_in  = diff_ff;
      range_in = range_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;
      res_in   = res_ff;
      out_in   = out_ff;
      if (cmd.read) begin
         raw_in = raw;
      end
      if (cmd.pick) begin
         diff_in  = t_clamp - min_time;
         range_in = max_time - min_time;
         if (!use_div) begin
            res_in[cmd.field] = direct_value;
         end
      end
      if (cmd.mul) begin
         rem_in = rrt_pkg::PROD_BITS'(diff_ff) * rrt_pkg::PROD_BITS'(rrt_pkg::MAP_SCALE);
         dsr_in = rrt_pkg::PROD_BITS'(range_ff) << (rrt_pkg::Q_BITS - 1);
         quo_in = '0;
      end
      if (cmd.div_step) begin
         if (div_ge) begin
            rem_in = rem_ff - dsr_ff;
         end
         dsr_in = dsr_ff >> 1;
         quo_in = {quo_ff[rrt_pkg::Q_BITS-2:0], div_ge};
      end
      if (cmd.store) begin
         res_in[cmd.field] = rrt_pkg::OUT_BITS'(quo_ff) + rrt_pkg::OUT_BITS'(1);
      end
      if (cmd.load_out) begin
         out_in = res_ff;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         prev_ff  <= '1;
         edge_ff  <= '0;
      end else begin
         count_ff <= count_in;
         prev_ff  <= prev_in;
         edge_ff  <= edge_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      raw_ff   <= raw_in;
      diff_ff  <= diff_in;
      range_ff <= range_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      quo_ff   <= quo_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end

   assign out_value = out_ff;

endmodule

`default_nettype wire

// ----- hdl/rrt_ctrl.sv -----
`default_nettype none

module rrt_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic [rrt_pkg::MODE_BITS-1:0]  req_mode,
   output logic                                req_ready,
   input  wire logic                           rsp_ready,
   output logic                                rsp_valid,
   output rrt_pkg::rrt_cmd_type                cmd,
   input  wire rrt_pkg::rrt_status_type        status
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PICK  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_STORE = 3'd4;
   localparam logic [2:0] S_FLUSH = 3'd5;

   localparam logic [rrt_pkg::FIELD_BITS-1:0] LAST_FIELD =
      rrt_pkg::FIELD_BITS'(rrt_pkg::OUT_FIELDS - 1);
   localparam logic [rrt_pkg::STEP_BITS-1:0] FIRST_STEP =
      rrt_pkg::STEP_BITS'(rrt_pkg::Q_BITS - 1);

   logic [2:0]                     state_ff, state_in;
   logic [rrt_pkg::FIELD_BITS-1:0] field_ff, field_in;
   logic [rrt_pkg::STEP_BITS-1:0]  step_ff, step_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Sequencer: one field at a time, divider steps counted down.
   always_comb begin
      state_in     = state_ff;
      field_in     = field_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.field    = field_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_mode)
                  rrt_pkg::MODE_TICK: begin
                     cmd.tick = 1'b1;
                  end
                  rrt_pkg::MODE_START: begin
                     cmd.start = 1'b1;
                  end
                  rrt_pkg::MODE_READ: begin
                     cmd.read = 1'b1;
                     field_in = '0;
                     state_in = S_PICK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            if (status.use_div) begin
               state_in = S_MUL;
            end else if (field_ff == LAST_FIELD) begin
               state_in = S_FLUSH;
            end else begin
               field_in = field_ff + rrt_pkg::FIELD_BITS'(1);
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            step_in  = FIRST_STEP;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = S_STORE;
            end else begin
               step_in = step_ff - rrt_pkg::STEP_BITS'(1);
            end
         end
         S_STORE: begin
            cmd.store = 1'b1;
            if (field_ff == LAST_FIELD) begin
               state_in = S_FLUSH;
            end else begin
               field_in = field_ff + rrt_pkg::FIELD_BITS'(1);
               state_in = S_PICK;
            end
         end
         S_FLUSH: begin
            // Wait for the output register to drain before reloading it.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         field_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         field_ff     <= field_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/rc_reflectance_timer_4ch.sv -----
`default_nettype none

// Tick and start transactions may follow back to back.
// A read visits each field in turn: one with no edge, raw or degenerate range is set
// directly, and a mapped one goes through clamp, multiply, 10 steps of the
// shared divider and store; the output then loads once any waiting result is taken.
// No new transaction is taken during a read; a waiting result does not block ticks.
// Synchronous reset clears the counter, captures and control; registers reload defaults.
module rc_reflectance_timer_4ch #(
   parameter int TIME_BITS = 16,
   parameter int CHANNELS  = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   rrt_req_if.sink                                 req_ch,
   rrt_rsp_if.source                               rsp_ch,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [rrt_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [rrt_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [rrt_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                    csr_pready
);

   logic [rrt_pkg::CFG_BITS-1:0] min_ff, min_in;
   logic [rrt_pkg::CFG_BITS-1:0] max_ff, max_in;
   logic                         csr_write;
   logic                         reg_sel;

   rrt_pkg::rrt_cmd_type                                  cmd;
   rrt_pkg::rrt_status_type                               status;
   logic [rrt_pkg::OUT_FIELDS-1:0][rrt_pkg::OUT_BITS-1:0] out_value;

   // Register file: the word address bit selects the register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (csr_write) begin
         if (reg_sel == rrt_pkg::REG_MIN_TIME) begin
            min_in = csr_pwdata[rrt_pkg::CFG_BITS-1:0];
         end else begin
            max_in = csr_pwdata[rrt_pkg::CFG_BITS-1:0];
         end
      end
      if (reg_sel == rrt_pkg::REG_MAX_TIME) begin
         csr_prdata = rrt_pkg::CSR_DATA_BITS'(max_ff);
      end else begin
         csr_prdata = rrt_pkg::CSR_DATA_BITS'(min_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= rrt_pkg::MIN_TIME_RESET;
         max_ff <= rrt_pkg::MAX_TIME_RESET;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   // Controller.
   rrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath.
   rrt_dp #(
      .TIME_BITS (TIME_BITS),
      .CHANNELS  (CHANNELS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .line_levels (req_ch.line_levels),
      .raw         (req_ch.raw),
      .min_time    (min_ff),
      .max_time    (max_ff),
      .out_value   (out_value)
   );

   assign rsp_ch.front_left_value  = out_value[0];
   assign rsp_ch.front_right_value = out_value[1];
   assign rsp_ch.rear_left_value   = out_value[2];
   assign rsp_ch.rear_right_value  = out_value[3];

   // A read transaction holds off the input side on the next cycle.
   a_read_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.mode == rrt_pkg::MODE_READ) |=> !req_ch.ready)
      else $error("input still ready after a read transaction");

   // A result appears only after the sequencer has left idle.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(!req_ch.ready))
      else $error("result raised without a read in progress");

   // Tick and start transactions never produce a result.
   a_no_rsp_on_tick: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.mode != rrt_pkg::MODE_READ && !rsp_ch.valid)
      |=> !rsp_ch.valid)
      else $error("result raised by a tick or start transaction");

endmodule

`default_nettype wire

// ----- verif/tb_rc_reflectance_timer_4ch.sv -----
`timescale 1ns / 1ps

module tb_rc_reflectance_timer_4ch;

   // Mode code that the block ignores.
   localparam logic [rrt_pkg::MODE_BITS-1:0] MODE_UNUSED  = 2'd3;
   localparam logic [rrt_pkg::OUT_BITS-1:0]  TIME_TOP     = '1;
   localparam int                            DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [rrt_pkg::MODE_BITS-1:0]  mode;
      logic [rrt_pkg::LEVEL_BITS-1:0] levels;
      logic                           raw;
   } sensor_item_type;

   typedef logic [rrt_pkg::OUT_FIELDS-1:0][rrt_pkg::OUT_BITS-1:0] readout_type;

   localparam string FIELD_NAMES [rrt_pkg::OUT_FIELDS] = '{
      "front_left_value", "front_right_value", "rear_left_value", "rear_right_value"
   };

   logic clock = 1'b0;
   logic reset;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [rrt_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [rrt_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [rrt_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   rrt_req_if req_if ();
   rrt_rsp_if rsp_if ();

   // Pending input transactions and readouts still owed by the block.
   sensor_item_type item_q [$];
   readout_type     readout_q [$];

   // Shadow of the block's state and registers.
   logic [rrt_pkg::OUT_BITS-1:0]   elapsed_us;
   logic [rrt_pkg::LEVEL_BITS-1:0] line_prev;
   logic [rrt_pkg::OUT_BITS-1:0]   edge_us [rrt_pkg::OUT_FIELDS];
   logic [rrt_pkg::CFG_BITS-1:0]   range_lo;
   logic [rrt_pkg::CFG_BITS-1:0]   range_hi;

   int  send_idle_pct;
   int  stall_pct;
   int  fail_count;
   logic req_taken;

   rc_reflectance_timer_4ch #(
      .TIME_BITS(16),
      .CHANNELS (4)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_if.sink),
      .rsp_ch     (rsp_if.source),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Clock with a 10 ns period.
   always begin
      #5ns clock = 1'b1;
      #5ns clock = 1'b0;
   end

   // Linear map of a captured time onto 1..1000 with clamping to the range.
   function automatic logic [rrt_pkg::OUT_BITS-1:0] scale_time(
      input logic [rrt_pkg::OUT_BITS-1:0] t);
      logic [31:0] clamped;
      logic [31:0] span;
      if (range_hi <= range_lo) begin
         return 16'd1;
      end
      clamped = 32'(t);
      if (clamped < 32'(range_lo)) begin
         clamped = 32'(range_lo);
      end
      if (clamped > 32'(range_hi)) begin
         clamped = 32'(range_hi);
      end
      span = 32'(range_hi) - 32'(range_lo);
      return rrt_pkg::OUT_BITS'((clamped - 32'(range_lo)) * 32'(rrt_pkg::MAP_TOP - 1) / span
                                + 32'd1);
   endfunction

   // Applies one accepted transaction to the shadow state and queues any readout.
   function automatic void track_transaction(input sensor_item_type it);
      readout_type vals;
      vals = '0;
      case (it.mode)
         rrt_pkg::MODE_START: begin
            elapsed_us = '0;
            edge_us = '{default: '0};
         end
         rrt_pkg::MODE_TICK: begin
            if (elapsed_us != TIME_TOP) begin
               elapsed_us = elapsed_us + 1'b1;
            end
            for (int c = 0; c < rrt_pkg::OUT_FIELDS; c++) begin
               if (line_prev[c] && !it.levels[c]) begin
                  edge_us[c] = elapsed_us;
               end
            end
            line_prev = it.levels;
         end
         rrt_pkg::MODE_READ: begin
            for (int c = 0; c < rrt_pkg::OUT_FIELDS; c++) begin
               if (edge_us[c] != '0) begin
                  vals[c] = it.raw ? edge_us[c] : scale_time(edge_us[c]);
               end
            end
            readout_q.push_back(vals);
            edge_us = '{default: '0};
         end
         default: begin
         end
      endcase
   endfunction

   // Input driver: presents queued transactions, idling at random.
   always @(negedge clock) begin
      sensor_item_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (item_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            nxt = item_q.pop_front();
            req_if.valid       <= 1'b1;
            req_if.mode        <= nxt.mode;
            req_if.line_levels <= nxt.levels;
            req_if.raw         <= nxt.raw;
         end else begin
            req_if.valid       <= 1'b0;
            req_if.mode        <= rrt_pkg::MODE_BITS'($urandom_range(3, 0));
            req_if.line_levels <= rrt_pkg::LEVEL_BITS'($urandom_range(15, 0));
            req_if.raw         <= 1'($urandom_range(1, 0));
         end
      end
   end

   // Result side back-pressure.
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99, 0) >= stall_pct);
   end

   // Monitor: predicts on each accepted input, checks each accepted readout.
   always @(posedge clock) begin
      readout_type got;
      readout_type want;
      req_taken = !reset && req_if.valid && req_if.ready;
      if (req_taken) begin
         track_transaction('{mode: req_if.mode, levels: req_if.line_levels,
                             raw: req_if.raw});
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got[0] = rsp_if.front_left_value;
         got[1] = rsp_if.front_right_value;
         got[2] = rsp_if.rear_left_value;
         got[3] = rsp_if.rear_right_value;
         if (readout_q.size() == 0) begin
            $error("readout with none outstanding: %h", got);
            fail_count++;
         end else begin
            want = readout_q.pop_front();
            for (int j = 0; j < rrt_pkg::OUT_FIELDS; j++) begin
               if (got[j] !== want[j]) begin
                  $error("%s: expected %0d, actual %0d", FIELD_NAMES[j], want[j], got[j]);
                  fail_count++;
               end
            end
         end
      end
   end

   // APB write of one register; the shadow copy follows at the write edge.
   task automatic csr_write(input logic sel, input logic [rrt_pkg::CFG_BITS-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= rrt_pkg::CSR_ADDR_BITS'({sel, 2'b00});
      csr_pwdata  <= {16'($urandom_range(65535, 0)), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (sel == rrt_pkg::REG_MAX_TIME) begin
         range_hi = value;
      end else begin
         range_lo = value;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic queue_item(input logic [rrt_pkg::MODE_BITS-1:0] mode,
                             input logic [rrt_pkg::LEVEL_BITS-1:0] levels, input logic raw);
      item_q.push_back('{mode: mode, levels: levels, raw: raw});
   endtask

   // Waits until every transaction is taken and every readout is back.
   task automatic wait_drained();
      while (item_q.size() != 0 || req_if.valid || readout_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic reconfigure(input logic [rrt_pkg::CFG_BITS-1:0] lo,
                              input logic [rrt_pkg::CFG_BITS-1:0] hi,
                              input int send_pct, input int stall);
      wait_drained();
      csr_write(rrt_pkg::REG_MIN_TIME, lo);
      csr_write(rrt_pkg::REG_MAX_TIME, hi);
      send_idle_pct = send_pct;
      stall_pct     = stall;
   endtask

   // Mostly start, a burst of ticks and a read; the rest is loose transactions.
   task automatic plan_traffic(input int target);
      int planned;
      int ticks;
      logic [rrt_pkg::LEVEL_BITS-1:0] held_high;
      logic [rrt_pkg::MODE_BITS-1:0]  mode;
      planned = 0;
      while (planned < target) begin
         if ($urandom_range(99, 0) < 80) begin
            if ($urandom_range(99, 0) < 70) begin
               queue_item(rrt_pkg::MODE_START, rrt_pkg::LEVEL_BITS'($urandom_range(15, 0)),
                          1'($urandom_range(1, 0)));
               planned++;
            end
            held_high = rrt_pkg::LEVEL_BITS'($urandom_range(15, 0) & $urandom_range(15, 0));
            ticks = $urandom_range(24, 1);
            repeat (ticks) begin
               queue_item(rrt_pkg::MODE_TICK,
                          rrt_pkg::LEVEL_BITS'($urandom_range(15, 0)) | held_high,
                          1'($urandom_range(1, 0)));
            end
            planned += ticks;
            queue_item(rrt_pkg::MODE_READ, rrt_pkg::LEVEL_BITS'($urandom_range(15, 0)),
                       1'($urandom_range(1, 0)));
            planned++;
         end else begin
            mode = rrt_pkg::MODE_BITS'($urandom_range(3, 0));
            queue_item(mode, rrt_pkg::LEVEL_BITS'($urandom_range(15, 0)),
                       1'($urandom_range(1, 0)));
            if (mode != MODE_UNUSED) begin
               planned++;
            end
         end
      end
   endtask

   // Stimulus sequence.
   initial begin
      reset              = 1'b1;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      req_if.valid       = 1'b0;
      req_if.mode        = rrt_pkg::MODE_TICK;
      req_if.line_levels = '1;
      req_if.raw         = 1'b0;
      rsp_if.ready       = 1'b1;
      req_taken          = 1'b0;
      send_idle_pct      = 0;
      stall_pct          = 0;
      fail_count         = 0;
      elapsed_us         = '0;
      line_prev          = '1;
      edge_us            = '{default: '0};
      range_lo           = rrt_pkg::MIN_TIME_RESET;
      range_hi           = rrt_pkg::MAX_TIME_RESET;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty read, raw read, levels ignored outside ticks, unused mode,
      // overwritten captures, start, and reads in both modes with reset registers.
      queue_item(rrt_pkg::MODE_READ,  4'h0, 1'b0);
      queue_item(rrt_pkg::MODE_TICK,  4'hF, 1'b0);
      queue_item(rrt_pkg::MODE_TICK,  4'h0, 1'b0);
      queue_item(rrt_pkg::MODE_READ,  4'hF, 1'b1);
      queue_item(rrt_pkg::MODE_TICK,  4'h0, 1'b0);
      queue_item(rrt_pkg::MODE_READ,  4'h0, 1'b0);
      queue_item(rrt_pkg::MODE_TICK,  4'hA, 1'b0);
      queue_item(rrt_pkg::MODE_TICK,  4'h5, 1'b0);
      queue_item(MODE_UNUSED,         4'hF, 1'b1);
      queue_item(rrt_pkg::MODE_TICK,  4'h0, 1'b0);
      queue_item(rrt_pkg::MODE_TICK,  4'hF, 1'b0);
      queue_item(rrt_pkg::MODE_TICK,  4'h6, 1'b0);
      queue_item(rrt_pkg::MODE_READ,  4'h0, 1'b0);
      queue_item(rrt_pkg::MODE_START, 4'hF, 1'b1);
      queue_item(rrt_pkg::MODE_TICK,  4'h0, 1'b0);
      queue_item(rrt_pkg::MODE_READ,  4'h0, 1'b1);
      queue_item(MODE_UNUSED,         4'h0, 1'b0);
      queue_item(rrt_pkg::MODE_READ,  4'h0, 1'b0);
      queue_item(rrt_pkg::MODE_READ,  4'h0, 1'b1);
      queue_item(rrt_pkg::MODE_TICK,  4'hF, 1'b0);
      queue_item(rrt_pkg::MODE_TICK,  4'h0, 1'b0);
      queue_item(rrt_pkg::MODE_READ,  4'h0, 1'b0);
      plan_traffic(150);

      // Register settings and idle patterns, extremes included.
      reconfigure(16'd0, 16'd65535, 0, 0);
      plan_traffic(130);
      reconfigure(16'd5, 16'd30, 82, 0);
      plan_traffic(150);
      reconfigure(16'd65535, 16'd65535, 0, 82);
      plan_traffic(140);
      reconfigure(16'd3, 16'd20, 35, 35);
      plan_traffic(150);
      reconfigure(16'd40, 16'd2, 0, 0);
      plan_traffic(120);
      reconfigure(16'($urandom_range(15, 0)), 16'($urandom_range(40, 0)), 82, 0);
      plan_traffic(150);
      reconfigure(16'($urandom_range(15, 0)), 16'($urandom_range(40, 0)), 0, 82);
      plan_traffic(150);
      reconfigure(16'd0, 16'd0, 35, 35);
      plan_traffic(120);
      reconfigure(16'd2, 16'd12, 0, 0);
      plan_traffic(150);

      wait_drained();
      if (fail_count == 0) begin
         $display("rc_reflectance_timer_4ch test passed");
      end else begin
         $display("rc_reflectance_timer_4ch test failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #20ms;
      $display("rc_reflectance_timer_4ch test failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/rrt_pkg.sv
hdl/rrt_req_if.sv
hdl/rrt_rsp_if.sv
hdl/rrt_dp.sv
hdl/rrt_ctrl.sv
hdl/rc_reflectance_timer_4ch.sv
verif/tb_rc_reflectance_timer_4ch.sv
